FILE: hdl/bsram_pkg.sv
// Package for the battery SRAM bus slave: payload types, codes and constants.
package bsram_pkg;

   localparam int STORE_WORDS = 32768;
   localparam int ADDR_W      = $clog2(STORE_WORDS);
   localparam int STORE_BYTES = STORE_WORDS * 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [1:0] REQ_READ   = 2'd0;
   localparam logic [1:0] REQ_WRITE  = 2'd1;
   localparam logic [1:0] REQ_ENABLE = 2'd2;
   localparam logic [1:0] REQ_BOOT   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC = 2'd1;

   localparam logic [15:0] SWITCH_OFFSET = 16'h0009;
   localparam logic [7:0]  SWITCH_VALUE  = 8'h10;
   localparam logic [23:0] BOOT_PC       = 24'hFF03A8;
   localparam logic [15:0] BOOT_COUNTER  = 16'h0044;
   localparam logic [15:0] ERASED_WORD   = 16'hFFFF;
   localparam logic [15:0] ERROR_DATA    = 16'h00FF;

   localparam logic [ADDR_W-1:0] BOOT_HI_IDX = ADDR_W'(BOOT_COUNTER >> 1);
   localparam logic [ADDR_W-1:0] BOOT_LO_IDX = ADDR_W'((BOOT_COUNTER >> 1) + 16'd1);
   localparam logic [16:0]       STORE_CAP   = 17'(STORE_BYTES);

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] offset;
      logic        is_word;
      logic [15:0] write_value;
      logic [23:0] cpu_pc;
      logic        enable_value;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        bus_error;
      logic        contents_changed;
   } rsp_payload_type;

   // word accesses ignore bit 0 of the offset
   function automatic logic [15:0] eff_offset(input logic [15:0] offset, input logic is_word);
      eff_offset = is_word ? {offset[15:1], 1'b0} : offset;
   endfunction

endpackage

FILE: hdl/battery_sram_bus_slave_unit.sv
// Battery SRAM bus slave top level: request sequencer around the word store.
// Bus error and write-enable items are answered from idle; reads and writes pass
// through ST_RD, boot increments through ST_BOOT_LO (and ST_BOOT_HI when the low
// counter word carries), for the read-modify-write through the store's registered
// read port; one item at a time. Reset is synchronous; afterwards a clearing pass
// fills the store with ones; no item is taken then (configuration writes still are).
module battery_sram_bus_slave_unit (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  bsram_pkg::req_payload_type                 req_payload,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output bsram_pkg::rsp_payload_type                 rsp_payload,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [bsram_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [bsram_pkg::CSR_DATA_W-1:0]           csr_wdata
);

   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_RD      = 3'd2;
   localparam logic [2:0] ST_BOOT_LO = 3'd3;
   localparam logic [2:0] ST_BOOT_HI = 3'd4;
   localparam logic [2:0] ST_RESP    = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [bsram_pkg::ADDR_W-1:0] clear_ff, clear_in;
   logic [2:0] size_units_ff, size_units_in;
   logic sync_mode_ff, sync_mode_in;
   logic write_allowed_ff, write_allowed_in;
   logic dirty_ff, dirty_in;
   logic rsp_valid_ff, rsp_valid_in;
   bsram_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   bsram_pkg::rsp_payload_type hold_ff, hold_in;
   bsram_pkg::req_payload_type item_ff, item_in;

   logic ram_we, ram_re;
   logic [bsram_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [15:0] ram_wdata, ram_rdata;

   logic [2:0]  units;
   logic [16:0] pop_raw, pop_bytes;
   logic [15:0] req_eff, item_eff;
   logic        req_err;
   logic [bsram_pkg::ADDR_W-1:0] req_idx, item_idx;
   logic [7:0]  wr_byte;
   logic        suppress;
   logic [15:0] new_word, rd_value;
   logic        out_free;
   logic        res_valid;
   bsram_pkg::rsp_payload_type res;

   bsram_ram #(
      .WIDTH(16),
      .DEPTH(bsram_pkg::STORE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      if (size_units_ff == 3'd0) begin
         units = 3'd1;
      end else if (size_units_ff > 3'd4) begin
         units = 3'd4;
      end else begin
         units = size_units_ff;
      end
      pop_raw   = {units, 14'b0};
      pop_bytes = (pop_raw > bsram_pkg::STORE_CAP) ? bsram_pkg::STORE_CAP : pop_raw;
   end

   assign req_eff  = bsram_pkg::eff_offset(req_payload.offset, req_payload.is_word);
   assign req_err  = {1'b0, req_eff} >= pop_bytes;
   assign req_idx  = req_eff[bsram_pkg::ADDR_W:1];
   assign item_eff = bsram_pkg::eff_offset(item_ff.offset, item_ff.is_word);
   assign item_idx = item_eff[bsram_pkg::ADDR_W:1];

   assign wr_byte  = item_ff.write_value[7:0];
   assign suppress = !item_ff.is_word && item_eff == bsram_pkg::SWITCH_OFFSET &&
                     wr_byte == bsram_pkg::SWITCH_VALUE &&
                     item_ff.cpu_pc == bsram_pkg::BOOT_PC && sync_mode_ff;

   always_comb begin
      if (item_ff.is_word) begin
         new_word = item_ff.write_value;
         rd_value = ram_rdata;
      end else if (item_eff[0]) begin
         new_word = {ram_rdata[15:8], wr_byte};
         rd_value = {8'h00, ram_rdata[7:0]};
      end else begin
         new_word = {wr_byte, ram_rdata[7:0]};
         rd_value = {8'h00, ram_rdata[15:8]};
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = reset || state_ff != ST_IDLE;
   assign csr_ready = !reset;

   always_comb begin
      state_in         = state_ff;
      clear_in         = clear_ff;
      size_units_in    = size_units_ff;
      sync_mode_in     = sync_mode_ff;
      write_allowed_in = write_allowed_ff;
      dirty_in         = dirty_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_data_in      = rsp_data_ff;
      hold_in          = hold_ff;
      item_in          = item_ff;
      ram_we           = 1'b0;
      ram_waddr        = clear_ff;
      ram_wdata        = bsram_pkg::ERASED_WORD;
      ram_re           = 1'b0;
      ram_raddr        = req_idx;
      res_valid        = 1'b0;
      res              = '0;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bsram_pkg::CSR_SIZE: size_units_in = csr_wdata[2:0];
            bsram_pkg::CSR_SYNC: sync_mode_in  = csr_wdata[0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we   = 1'b1;
            clear_in = clear_ff + 1'b1;
            if (clear_ff == bsram_pkg::ADDR_W'(bsram_pkg::STORE_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_payload;
               case (req_payload.req_type) inside
                  bsram_pkg::REQ_READ, bsram_pkg::REQ_WRITE: begin
                     if (req_err) begin
                        res_valid     = 1'b1;
                        res.read_data = bsram_pkg::ERROR_DATA;
                        res.bus_error = 1'b1;
                     end else begin
                        ram_re   = 1'b1;
                        state_in = ST_RD;
                     end
                  end
                  bsram_pkg::REQ_ENABLE: begin
                     write_allowed_in = req_payload.enable_value;
                     res_valid        = 1'b1;
                  end
                  default: begin
                     ram_re    = 1'b1;
                     ram_raddr = bsram_pkg::BOOT_LO_IDX;
                     state_in  = ST_BOOT_LO;
                  end
               endcase
            end
         end
         ST_RD: begin
            res_valid = 1'b1;
            if (item_ff.req_type == bsram_pkg::REQ_READ) begin
               res.read_data = rd_value;
            end else if (write_allowed_ff && !suppress && new_word != ram_rdata) begin
               ram_we    = 1'b1;
               ram_waddr = item_idx;
               ram_wdata = new_word;
               dirty_in  = 1'b1;
            end
         end
         ST_BOOT_LO: begin
            dirty_in  = 1'b1;
            ram_we    = 1'b1;
            ram_waddr = bsram_pkg::BOOT_LO_IDX;
            if (ram_rdata != bsram_pkg::ERASED_WORD) begin
               ram_wdata = ram_rdata + 16'd1;
               res_valid = 1'b1;
            end else begin
               ram_wdata = 16'h0000;
               ram_re    = 1'b1;
               ram_raddr = bsram_pkg::BOOT_HI_IDX;
               state_in  = ST_BOOT_HI;
            end
         end
         ST_BOOT_HI: begin
            ram_we    = 1'b1;
            ram_waddr = bsram_pkg::BOOT_HI_IDX;
            ram_wdata = ram_rdata + 16'd1;
            res_valid = 1'b1;
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = hold_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      res.contents_changed = dirty_in;

      if (res_valid) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = res;
            state_in     = ST_IDLE;
         end else begin
            hold_in  = res;
            state_in = ST_RESP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clear_ff         <= '0;
         size_units_ff    <= 3'd1;
         sync_mode_ff     <= 1'b1;
         write_allowed_ff <= 1'b0;
         dirty_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         clear_ff         <= clear_in;
         size_units_ff    <= size_units_in;
         sync_mode_ff     <= sync_mode_in;
         write_allowed_ff <= write_allowed_in;
         dirty_ff         <= dirty_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      hold_ff     <= hold_in;
      item_ff     <= item_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_clear_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !dirty_ff && !rsp_valid_ff)
      else $error("store clearing pass with a changed flag or a pending item");

   a_boot_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BOOT_HI |-> $past(state_ff) == ST_BOOT_LO)
      else $error("boot high word update without low word carry");

   a_dirty_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !$fell(dirty_ff))
      else $error("changed flag cleared outside reset");
`endif

endmodule

FILE: hdl/bsram_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module bsram_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: verif/tb_battery_sram_bus_slave_unit.sv
// Testbench for the battery SRAM bus slave: directed and random traffic against a predictor.
`timescale 1ns / 1ps

module tb_battery_sram_bus_slave_unit;

   localparam int            IMAGE_WORDS      = bsram_pkg::STORE_WORDS;
   localparam logic [15:0]   COUNTER_OFF      = 16'h0044;
   localparam int            COUNTER_HI       = 16'h0044 >> 1;
   localparam int            COUNTER_LO       = (16'h0044 >> 1) + 1;
   localparam logic [15:0]   SYNC_SWITCH_OFF  = 16'h0009;
   localparam logic [7:0]    SYNC_SWITCH_VAL  = 8'h10;
   localparam logic [23:0]   SYNC_PC          = 24'hFF03A8;
   localparam logic [15:0]   ERASED           = 16'hFFFF;
   localparam logic [15:0]   BUS_ERR_DATA     = 16'h00FF;
   localparam logic [bsram_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [bsram_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;
   localparam int            RANDOM_PER_PHASE = 200;
   localparam int            HOLD_CYCLES      = 300;
   localparam int            CYCLE_LIMIT      = 600000;

   logic                                 clock       = 1'b0;
   logic                                 reset       = 1'b1;
   logic                                 req_valid   = 1'b0;
   logic                                 req_stall;
   bsram_pkg::req_payload_type           req_payload = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   bsram_pkg::rsp_payload_type           rsp_payload;
   logic                                 csr_valid   = 1'b0;
   logic                                 csr_ready;
   logic [bsram_pkg::CSR_IDX_W-1:0]      csr_index   = '0;
   logic [bsram_pkg::CSR_DATA_W-1:0]     csr_wdata   = '0;

   logic                    tx_idle_on  = 1'b1;
   logic                    rx_idle_on  = 1'b1;
   logic                    burst_stall = 1'b0;
   logic                    hold_stall  = 1'b0;
   int unsigned             burst_left  = 0;
   event                    hold_trigger;

   // predictor state
   logic [15:0]             sram_image [IMAGE_WORDS];
   logic                    image_write_en;
   logic                    image_dirty;
   logic [2:0]              size_units;
   logic                    sync_mode;

   bsram_pkg::rsp_payload_type due_rsp [$];
   int unsigned             cycle_count    = 0;
   int unsigned             mismatch_count = 0;
   int unsigned             items_sent     = 0;
   int unsigned             rsp_checked    = 0;
   int unsigned             write_count    = 0;
   int unsigned             boot_count     = 0;
   int unsigned             error_count    = 0;
   int unsigned             setting_count  = 0;

   battery_sram_bus_slave_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
                  due_rsp.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   assign rsp_stall = burst_stall | hold_stall;

   always @(posedge clock) begin
      if (reset || !rx_idle_on) begin
         burst_stall <= 1'b0;
         burst_left  <= 0;
      end else if (burst_left != 0) begin
         burst_left <= burst_left - 1;
      end else if (burst_stall) begin
         burst_stall <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
         burst_stall <= 1'b1;
         burst_left  <= $urandom_range(0, 17);
      end
   end

   initial begin
      forever begin
         @(hold_trigger);
         hold_stall <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_stall <= 1'b0;
      end
   end

   task automatic note_mismatch(input string field, input logic [15:0] want,
                                input logic [15:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch at cycle %0d on %s: expected %h, got %h", cycle_count, field,
                  want, got);
   endtask

   always @(posedge clock) begin : rsp_check
      bsram_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_rsp.size() == 0) begin
            note_mismatch("unexpected item", '0, rsp_payload.read_data);
         end else begin
            want = due_rsp.pop_front();
            rsp_checked++;
            if (rsp_payload.read_data !== want.read_data)
               note_mismatch("read_data", want.read_data, rsp_payload.read_data);
            if (rsp_payload.bus_error !== want.bus_error)
               note_mismatch("bus_error", 16'(want.bus_error), 16'(rsp_payload.bus_error));
            if (rsp_payload.contents_changed !== want.contents_changed)
               note_mismatch("contents_changed", 16'(want.contents_changed),
                             16'(rsp_payload.contents_changed));
         end
      end
   end

   function automatic int unsigned populated_limit();
      int unsigned units;
      units = size_units;
      if (units < 1) units = 1;
      if (units > 4) units = 4;
      if (units * 16384 > IMAGE_WORDS * 2) return IMAGE_WORDS * 2;
      return units * 16384;
   endfunction

   function automatic bsram_pkg::rsp_payload_type predict_access(
         input bsram_pkg::req_payload_type item);
      bsram_pkg::rsp_payload_type r;
      logic [15:0]     off;
      logic [15:0]     w;
      logic [7:0]      b;
      r = '0;
      case (item.req_type) inside
         bsram_pkg::REQ_READ, bsram_pkg::REQ_WRITE: begin
            off = item.is_word ? {item.offset[15:1], 1'b0} : item.offset;
            if (item.req_type == bsram_pkg::REQ_WRITE) write_count++;
            if (off >= populated_limit()) begin
               r.bus_error = 1'b1;
               r.read_data = BUS_ERR_DATA;
               error_count++;
            end else if (item.req_type == bsram_pkg::REQ_READ) begin
               w = sram_image[off[15:1]];
               if (item.is_word) r.read_data = w;
               else r.read_data = {8'h00, off[0] ? w[7:0] : w[15:8]};
            end else if (image_write_en) begin
               w = sram_image[off[15:1]];
               b = item.write_value[7:0];
               if (item.is_word) begin
                  w = item.write_value;
               end else if (!(off == SYNC_SWITCH_OFF && b == SYNC_SWITCH_VAL &&
                              item.cpu_pc == SYNC_PC && sync_mode)) begin
                  if (off[0]) w[7:0] = b;
                  else w[15:8] = b;
               end
               if (w != sram_image[off[15:1]]) begin
                  sram_image[off[15:1]] = w;
                  image_dirty = 1'b1;
               end
            end
         end
         bsram_pkg::REQ_ENABLE: image_write_en = item.enable_value;
         default: begin
            boot_count++;
            image_dirty = 1'b1;
            if (sram_image[COUNTER_LO] != ERASED) begin
               sram_image[COUNTER_LO] = sram_image[COUNTER_LO] + 16'd1;
            end else begin
               sram_image[COUNTER_LO] = '0;
               sram_image[COUNTER_HI] = sram_image[COUNTER_HI] + 16'd1;
            end
         end
      endcase
      r.contents_changed = image_dirty;
      return r;
   endfunction

   task automatic send_item(input bsram_pkg::req_payload_type item);
      if (tx_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      due_rsp.push_back(predict_access(item));
      items_sent++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (due_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [bsram_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bsram_pkg::CSR_DATA_W-1:0] data,
                            input logic last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == bsram_pkg::CSR_SIZE) size_units = data[2:0];
      else if (idx == bsram_pkg::CSR_SYNC) sync_mode = data[0];
      if (last) csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [2:0] size, input logic sync);
      wait_for_drain();
      write_csr(bsram_pkg::CSR_SIZE, {5'($urandom), size}, 1'b0);
      write_csr(bsram_pkg::CSR_SYNC, {7'($urandom), sync}, 1'b1);
      setting_count++;
   endtask

   function automatic bsram_pkg::req_payload_type make_req(input logic [1:0] kind,
         input logic [15:0] off, input logic word, input logic [15:0] value);
      bsram_pkg::req_payload_type r;
      r.req_type     = kind;
      r.offset       = off;
      r.is_word      = word;
      r.write_value  = value;
      r.cpu_pc       = 24'($urandom);
      r.enable_value = 1'($urandom);
      return r;
   endfunction

   task automatic set_write_enable(input logic en);
      bsram_pkg::req_payload_type r;
      r = make_req(bsram_pkg::REQ_ENABLE, 16'($urandom), 1'($urandom), 16'($urandom));
      r.enable_value = en;
      send_item(r);
   endtask

   function automatic bsram_pkg::req_payload_type random_req();
      bsram_pkg::req_payload_type r;
      int unsigned     pick;
      logic [15:0]     w;
      r = make_req(bsram_pkg::REQ_READ, 16'($urandom), 1'($urandom), 16'($urandom));
      if ($urandom_range(0, 4) == 0) r.cpu_pc = SYNC_PC;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         r.req_type     = bsram_pkg::REQ_ENABLE;
         r.enable_value = ($urandom_range(0, 3) != 0);
      end else if (pick < 9) begin
         r.req_type = bsram_pkg::REQ_BOOT;
      end else begin
         r.req_type = ($urandom_range(0, 1) != 0) ? bsram_pkg::REQ_WRITE : bsram_pkg::REQ_READ;
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            r.offset = 16'($urandom_range(0, 63));
         end else if (pick < 50) begin
            r.offset = COUNTER_OFF + 16'($urandom_range(0, 7));
            if ($urandom_range(0, 2) == 0) r.write_value = ERASED;
         end else if (pick < 65) begin
            r.offset = 16'(populated_limit() - 8 + $urandom_range(0, 15));
         end else if (pick < 70) begin
            r.req_type = bsram_pkg::REQ_WRITE;
            r.is_word  = 1'b0;
            r.offset   = SYNC_SWITCH_OFF;
            r.write_value[7:0] = SYNC_SWITCH_VAL;
            if ($urandom_range(0, 3) != 0) r.cpu_pc = SYNC_PC;
         end
         // rewrite of the value already held
         if (r.req_type == bsram_pkg::REQ_WRITE && $urandom_range(0, 9) == 0) begin
            w = sram_image[r.offset[15:1]];
            if (r.is_word) r.write_value = w;
            else r.write_value[7:0] = r.offset[0] ? w[7:0] : w[15:8];
         end
      end
      return r;
   endfunction

   task automatic test_reset_state();
      send_item(make_req(bsram_pkg::REQ_READ, 16'h0000, 1'b1, 16'($urandom)));
      send_item(make_req(bsram_pkg::REQ_READ, 16'h3FFF, 1'b0, 16'($urandom)));
      send_item(make_req(bsram_pkg::REQ_READ, 16'h4000, 1'b0, 16'($urandom)));
      send_item(make_req(bsram_pkg::REQ_WRITE, 16'h0010, 1'b1, 16'h0000));
      send_item(make_req(bsram_pkg::REQ_WRITE, 16'hFFFF, 1'b0, 16'h0055));
   endtask

   task automatic test_size_extremes();
      set_config(3'd0, 1'b1);
      send_item(make_req(bsram_pkg::REQ_READ, 16'h4000, 1'b1, 16'($urandom)));
      wait_for_drain();
      write_csr(CSR_SPARE_LO, 8'($urandom), 1'b0);
      write_csr(CSR_SPARE_HI, 8'($urandom), 1'b0);
      set_config(3'd7, 1'b1);
      send_item(make_req(bsram_pkg::REQ_READ, 16'hFFFF, 1'b0, 16'($urandom)));
      send_item(make_req(bsram_pkg::REQ_READ, 16'hFFFF, 1'b1, 16'($urandom)));
   endtask

   task automatic test_write_paths();
      set_write_enable(1'b1);
      send_item(make_req(bsram_pkg::REQ_WRITE, 16'h0020, 1'b1, ERASED));
      send_item(make_req(bsram_pkg::REQ_WRITE, 16'h0011, 1'b1, 16'h1234));
      send_item(make_req(bsram_pkg::REQ_READ, 16'h0010, 1'b0, 16'($urandom)));
      send_item(make_req(bsram_pkg::REQ_READ, 16'h0011, 1'b0, 16'($urandom)));
      send_item(make_req(bsram_pkg::REQ_WRITE, 16'h0013, 1'b0, 16'hC3A5));
      send_item(make_req(bsram_pkg::REQ_READ, 16'h0012, 1'b1, 16'($urandom)));
      send_item(make_req(bsram_pkg::REQ_WRITE, 16'hFFFE, 1'b1, 16'h0000));
   endtask

   task automatic test_switch_sync();
      bsram_pkg::req_payload_type r;
      r = make_req(bsram_pkg::REQ_WRITE, SYNC_SWITCH_OFF, 1'b0,
                   {8'($urandom), SYNC_SWITCH_VAL});
      r.cpu_pc = SYNC_PC;
      send_item(r);
      send_item(make_req(bsram_pkg::REQ_READ, SYNC_SWITCH_OFF, 1'b0, 16'($urandom)));
      set_config(3'd1, 1'b0);
      send_item(r);
      send_item(make_req(bsram_pkg::REQ_READ, SYNC_SWITCH_OFF, 1'b0, 16'($urandom)));
   endtask

   task automatic test_boot_counter();
      set_write_enable(1'b0);
      send_item(make_req(bsram_pkg::REQ_BOOT, 16'($urandom), 1'($urandom), 16'($urandom)));
      send_item(make_req(bsram_pkg::REQ_READ, COUNTER_OFF + 16'd2, 1'b1, 16'($urandom)));
      set_write_enable(1'b1);
      send_item(make_req(bsram_pkg::REQ_WRITE, COUNTER_OFF + 16'd2, 1'b1, ERASED));
      send_item(make_req(bsram_pkg::REQ_BOOT, 16'($urandom), 1'($urandom), 16'($urandom)));
      send_item(make_req(bsram_pkg::REQ_READ, COUNTER_OFF, 1'b1, 16'($urandom)));
   endtask

   task automatic test_random_traffic();
      logic [2:0] sizes [7] = '{3'd4, 3'd0, 3'd2, 3'd7, 3'd3, 3'd5, 3'd1};
      logic       syncs [7] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      for (int p = 0; p < 7; p++) begin
         set_config(sizes[p], syncs[p]);
         repeat (RANDOM_PER_PHASE) send_item(random_req());
      end
   endtask

   task automatic test_backpressure();
      tx_idle_on <= 1'b0;
      -> hold_trigger;
      repeat (40) send_item(random_req());
   endtask

   task automatic test_steady_stream();
      rx_idle_on <= 1'b0;
      set_config(3'd4, 1'b1);
      repeat (RANDOM_PER_PHASE) send_item(random_req());
   endtask

   initial begin : stimulus
      for (int i = 0; i < IMAGE_WORDS; i++) sram_image[i] = ERASED;
      image_write_en = 1'b0;
      image_dirty    = 1'b0;
      size_units     = 3'd1;
      sync_mode      = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_size_extremes();
      test_write_paths();
      test_switch_sync();
      test_boot_counter();
      test_random_traffic();
      test_backpressure();
      test_steady_stream();

      wait_for_drain();
      repeat (20) @(posedge clock);
      $display("Sent %0d items over %0d size/sync settings: %0d writes, %0d boot increments,",
               items_sent, setting_count, write_count, boot_count);
      $display("%0d bus errors; %0d responses compared, %0d mismatches",
               error_count, rsp_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: files.f
hdl/bsram_pkg.sv
hdl/bsram_ram.sv
hdl/battery_sram_bus_slave_unit.sv
verif/tb_battery_sram_bus_slave_unit.sv
